// ----- rtl/cmvm_pkg.sv -----
package cmvm_pkg;

    localparam int MAX_DIM_DEF    = 256;
    localparam int ELEM_WIDTH_DEF = 16;
    localparam int CFG_W          = 9;
    localparam int CFG_IDX_W      = 8;
    localparam int ACC_W          = 42;
    localparam int ROW_W          = 8;
    localparam int WIDE_W         = 64;
    localparam int FIFO_DEPTH     = 4;
    localparam int OUT_TDATA_W    = ((ROW_W + 2 * ACC_W + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_ROWS = 8'd0,
        REG_NUM_COLS = 8'd1
    } t_cfg_reg;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_MATRIX = 1'b1
    } t_op;

    typedef struct packed {
        logic             first;
        logic             last_col;
        logic             last_row;
        logic [ROW_W-1:0] row_idx;
    } t_mac_ctl;

endpackage

// ----- rtl/cmvm_ram.sv -----
module cmvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/cmvm_front.sv -----
module cmvm_front
    import cmvm_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
    localparam int TDATA_W = ((2 * ELEM_WIDTH + 7) / 8) * 8,
    localparam int FIFO_W  = $bits(t_mac_ctl) + 4 * ELEM_WIDTH,
    localparam int LVL_W   = $clog2(FIFO_DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [TDATA_W-1:0]   s_axis_tdata,  // elem_re, elem_im
    input  logic [0:0]           s_axis_tuser,  // operation
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [LVL_W-1:0]     i_level,
    output logic                 o_push,
    output logic [FIFO_W-1:0]    o_push_data
);

    localparam int POS_W   = $clog2(MAX_DIM);
    localparam int SZ_W    = $clog2(MAX_DIM + 1);
    localparam int CW      = ((SZ_W > CFG_W) ? SZ_W : CFG_W) + 1;
    localparam int ENTRY_W = 2 * ELEM_WIDTH;

    logic [CFG_W-1:0]   r_num_rows;
    logic [CFG_W-1:0]   r_num_cols;
    logic [POS_W-1:0]   r_load_pos, n_load_pos;
    logic [POS_W-1:0]   r_col_pos, n_col_pos;
    logic [POS_W-1:0]   r_row_pos, n_row_pos;
    logic               r_s1_valid;
    t_mac_ctl           r_s1_ctl;
    logic [ENTRY_W-1:0] r_s1_a;

    logic [CW-1:0]      w_cols;
    logic [CW-1:0]      w_rows;
    logic               w_accept;
    logic               w_is_mat;
    logic               w_cfg_acc;
    logic               w_cfg_hit;
    logic               w_load_wrap;
    logic               w_col_end;
    logic               w_row_end;
    logic [ENTRY_W-1:0] w_elem;
    logic [ENTRY_W-1:0] w_x;

    function automatic logic [CW-1:0] eff_size(input logic [CFG_W-1:0] r);
        logic [CW-1:0] v;
        v = CW'(r);
        if (r == '0) begin
            v = CW'(1);
        end else if (v > CW'(MAX_DIM)) begin
            v = CW'(MAX_DIM);
        end
        return v;
    endfunction

    assign w_cols = eff_size(r_num_cols);
    assign w_rows = eff_size(r_num_rows);

    assign o_cfg_ready   = 1'b1;
    assign w_cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign w_cfg_hit     = w_cfg_acc &&
                           ((i_cfg_index == REG_NUM_ROWS) || (i_cfg_index == REG_NUM_COLS));
    assign s_axis_tready = ((LVL_W + 1)'(i_level) + (LVL_W + 1)'(r_s1_valid))
                           < (LVL_W + 1)'(FIFO_DEPTH);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_is_mat      = (s_axis_tuser[0] == OP_MATRIX);
    assign w_elem        = s_axis_tdata[ENTRY_W-1:0];

    assign w_load_wrap = (CW'(r_load_pos) + CW'(1)) >= w_cols;
    assign w_col_end   = (CW'(r_col_pos) + CW'(1)) >= w_cols;
    assign w_row_end   = (CW'(r_row_pos) + CW'(1)) >= w_rows;

    // vector store
    cmvm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_DIM)
    ) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && !w_is_mat),
        .i_waddr (r_load_pos),
        .i_wdata (w_elem),
        .i_re    (w_accept && w_is_mat),
        .i_raddr (r_col_pos),
        .o_rdata (w_x)
    );

    always_comb begin
        n_load_pos = r_load_pos;
        n_col_pos  = r_col_pos;
        n_row_pos  = r_row_pos;
        priority if (w_cfg_hit) begin
            n_load_pos = '0;
            n_col_pos  = '0;
            n_row_pos  = '0;
        end else if (w_accept && !w_is_mat) begin
            n_load_pos = w_load_wrap ? '0 : r_load_pos + POS_W'(1);
            n_col_pos  = '0;
            n_row_pos  = '0;
        end else if (w_accept) begin
            n_load_pos = '0;
            if (!w_col_end) begin
                n_col_pos = r_col_pos + POS_W'(1);
            end else begin
                n_col_pos = '0;
                n_row_pos = w_row_end ? '0 : r_row_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= CFG_W'(256);
            r_num_cols <= CFG_W'(256);
            r_load_pos <= '0;
            r_col_pos  <= '0;
            r_row_pos  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (w_cfg_acc) begin
                unique case (i_cfg_index)
                    REG_NUM_ROWS: r_num_rows <= i_cfg_data;
                    REG_NUM_COLS: r_num_cols <= i_cfg_data;
                    default: ;
                endcase
            end
            r_load_pos <= n_load_pos;
            r_col_pos  <= n_col_pos;
            r_row_pos  <= n_row_pos;
            r_s1_valid <= w_accept && w_is_mat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_is_mat) begin
            r_s1_ctl.first    <= (r_col_pos == '0);
            r_s1_ctl.last_col <= w_col_end;
            r_s1_ctl.last_row <= w_row_end;
            r_s1_ctl.row_idx  <= ROW_W'(r_row_pos);
            r_s1_a            <= w_elem;
        end
    end

    assign o_push      = r_s1_valid;
    assign o_push_data = {r_s1_ctl, r_s1_a, w_x};

endmodule

// ----- rtl/cmvm_fifo.sv -----
module cmvm_fifo #(
    parameter int WIDTH = 75,
    parameter int DEPTH = 4,
    localparam int PW    = $clog2(DEPTH),
    localparam int LVL_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_valid,
    output logic [LVL_W-1:0] o_level
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [LVL_W-1:0] r_level;
    logic             w_pop;

    assign w_pop = i_pop && (r_level != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            r_level <= r_level + LVL_W'(i_push) - LVL_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_valid = (r_level != '0);
    assign o_level = r_level;

endmodule

// ----- rtl/cmvm_back.sv -----
module cmvm_back
    import cmvm_pkg::*;
#(
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
    localparam int FIFO_W = $bits(t_mac_ctl) + 4 * ELEM_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [FIFO_W-1:0]      i_data,
    output logic                   o_pop,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // row_index, sum_re, sum_im
    output logic                   m_axis_tlast   // last_row
);

    localparam int EW = ELEM_WIDTH;
    localparam int PW = 2 * ELEM_WIDTH;

    logic signed [EW-1:0] w_x_re, w_x_im, w_a_re, w_a_im;
    t_mac_ctl             w_ctl;
    logic                 w_en;

    logic                 r_m_valid;
    t_mac_ctl             r_m_ctl;
    logic signed [PW-1:0] r_m_rr, r_m_ii, r_m_ri, r_m_ir;

    logic signed [WIDE_W-1:0] w_rr, w_ii, w_ri, w_ir;
    logic [ACC_W-1:0]     n_c_re, n_c_im;
    logic                 r_c_valid;
    t_mac_ctl             r_c_ctl;
    logic [ACC_W-1:0]     r_c_re, r_c_im;

    logic [ACC_W-1:0]     r_acc_re, r_acc_im;
    logic [ACC_W-1:0]     n_sum_re, n_sum_im;

    logic                 r_out_valid;
    logic [ROW_W-1:0]     r_out_row;
    logic [ACC_W-1:0]     r_out_re, r_out_im;
    logic                 r_out_last;

    assign w_x_re = $signed(i_data[EW-1:0]);
    assign w_x_im = $signed(i_data[2*EW-1:EW]);
    assign w_a_re = $signed(i_data[3*EW-1:2*EW]);
    assign w_a_im = $signed(i_data[4*EW-1:3*EW]);
    assign w_ctl  = i_data[FIFO_W-1:4*EW];

    // whole back end advances when the result slot is free or being taken
    assign w_en  = !r_out_valid || m_axis_tready;
    assign o_pop = w_en && i_valid;

    assign w_rr = WIDE_W'(r_m_rr);
    assign w_ii = WIDE_W'(r_m_ii);
    assign w_ri = WIDE_W'(r_m_ri);
    assign w_ir = WIDE_W'(r_m_ir);

    assign n_c_re = w_rr[ACC_W-1:0] - w_ii[ACC_W-1:0];
    assign n_c_im = w_ri[ACC_W-1:0] + w_ir[ACC_W-1:0];

    assign n_sum_re = (r_c_ctl.first ? '0 : r_acc_re) + r_c_re;
    assign n_sum_im = (r_c_ctl.first ? '0 : r_acc_im) + r_c_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_m_valid   <= i_valid;
            r_c_valid   <= r_m_valid;
            r_out_valid <= r_c_valid && r_c_ctl.last_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_ctl <= w_ctl;
            r_m_rr  <= w_a_re * w_x_re;
            r_m_ii  <= w_a_im * w_x_im;
            r_m_ri  <= w_a_re * w_x_im;
            r_m_ir  <= w_a_im * w_x_re;
            r_c_ctl <= r_m_ctl;
            r_c_re  <= n_c_re;
            r_c_im  <= n_c_im;
            if (r_c_valid) begin
                if (r_c_ctl.last_col) begin
                    r_out_row  <= r_c_ctl.row_idx;
                    r_out_re   <= n_sum_re;
                    r_out_im   <= n_sum_im;
                    r_out_last <= r_c_ctl.last_row;
                end else begin
                    r_acc_re <= n_sum_re;
                    r_acc_im <= n_sum_im;
                end
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out_im, r_out_re, r_out_row});
    assign m_axis_tlast  = r_out_last;

endmodule

// ----- rtl/complex_matrix_vector_multiply_top.sv -----
// Complex matrix-vector product y = A x on Q1.15 operands with exact 42-bit row sums.
// Vector elements (tuser 0) are written in order into a vector store RAM; matrix
// elements (tuser 1) follow row-major, and one result transfer leaves at the end of each
// row, with tlast on the final row. The block takes one item per clock unless stalled by
// tready: the vector store has one write and one registered read port, and the back end
// does one complex multiply-accumulate per cycle over three register stages.
// A four-entry queue sits between the front end and the multiply-accumulate, so input
// transfers continue while a result waits in the output register; a row sum passes
// through the queue and the three back-end registers. Write num_rows and num_cols only
// while the block is idle; each write restarts the vector load and the matrix position.
module complex_matrix_vector_multiply_top
    import cmvm_pkg::*;
#(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
    localparam int TDATA_W = ((2 * ELEM_WIDTH + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [TDATA_W-1:0]     s_axis_tdata,  // elem_re, elem_im
    input  logic [0:0]             s_axis_tuser,  // operation
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // row_index, sum_re, sum_im
    output logic                   m_axis_tlast,  // last_row
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    localparam int FIFO_W = $bits(t_mac_ctl) + 4 * ELEM_WIDTH;
    localparam int LVL_W  = $clog2(FIFO_DEPTH + 1);

    logic              w_push;
    logic [FIFO_W-1:0] w_push_data;
    logic [FIFO_W-1:0] w_q_data;
    logic              w_q_valid;
    logic              w_q_pop;
    logic [LVL_W-1:0]  w_q_level;

    cmvm_front #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_level       (w_q_level),
        .o_push        (w_push),
        .o_push_data   (w_push_data)
    );

    cmvm_fifo #(
        .WIDTH (FIFO_W),
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_q_pop),
        .o_data  (w_q_data),
        .o_valid (w_q_valid),
        .o_level (w_q_level)
    );

    cmvm_back #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_q_valid),
        .i_data        (w_q_data),
        .o_pop         (w_q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ----- verif/cmvm_row_checker.sv -----
`timescale 1ns / 100ps
module cmvm_row_checker
    import cmvm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [31:0]            s_axis_tdata,  // elem_re, elem_im
    input  logic [0:0]             s_axis_tuser,  // operation
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,  // row_index, sum_re, sum_im
    input  logic                   m_axis_tlast,  // last_row
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    output int                     o_errors,
    output int                     o_pending
);

    typedef struct {
        logic [ROW_W-1:0]        row;
        logic signed [ACC_W-1:0] re;
        logic signed [ACC_W-1:0] im;
        logic                    last;
    } t_row_sum;

    t_row_sum                          sums_due[$];
    logic [CFG_W-1:0]                  rows_reg;
    logic [CFG_W-1:0]                  cols_reg;
    logic signed [ELEM_WIDTH_DEF-1:0]  x_re [MAX_DIM_DEF];
    logic signed [ELEM_WIDTH_DEF-1:0]  x_im [MAX_DIM_DEF];
    int                                load_pos;
    int                                col_pos;
    int                                row_pos;
    logic signed [ACC_W-1:0]           acc_re;
    logic signed [ACC_W-1:0]           acc_im;
    int                                errors = 0;

    function automatic int dim_of(input logic [CFG_W-1:0] r);
        if (r == 0) return 1;
        if (r > MAX_DIM_DEF) return MAX_DIM_DEF;
        return int'(r);
    endfunction

    task automatic report(input string msg);
        $display("%0t row check: %s", $time, msg);
        errors++;
    endtask

    task automatic clear_positions();
        load_pos = 0;
        col_pos  = 0;
        row_pos  = 0;
        acc_re   = '0;
        acc_im   = '0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        unique case (idx)
            REG_NUM_ROWS: begin
                rows_reg = data;
                clear_positions();
            end
            REG_NUM_COLS: begin
                cols_reg = data;
                clear_positions();
            end
            default: ;
        endcase
    endtask

    task automatic accumulate(input t_op op, input logic signed [ELEM_WIDTH_DEF-1:0] a_re,
                              input logic signed [ELEM_WIDTH_DEF-1:0] a_im);
        logic signed [ACC_W-1:0] ar;
        logic signed [ACC_W-1:0] ai;
        logic signed [ACC_W-1:0] xr;
        logic signed [ACC_W-1:0] xi;
        int                      cols;
        int                      rows;
        t_row_sum                s;
        cols = dim_of(cols_reg);
        rows = dim_of(rows_reg);
        if (op == OP_LOAD) begin
            x_re[load_pos] = a_re;
            x_im[load_pos] = a_im;
            load_pos = (load_pos + 1 >= cols) ? 0 : load_pos + 1;
            col_pos  = 0;
            row_pos  = 0;
            acc_re   = '0;
            acc_im   = '0;
        end else begin
            load_pos = 0;
            ar = a_re;
            ai = a_im;
            xr = x_re[col_pos];
            xi = x_im[col_pos];
            acc_re = acc_re + ar * xr - ai * xi;
            acc_im = acc_im + ar * xi + ai * xr;
            if (col_pos + 1 < cols) begin
                col_pos++;
            end else begin
                s.row  = row_pos[ROW_W-1:0];
                s.re   = acc_re;
                s.im   = acc_im;
                s.last = (row_pos + 1 >= rows);
                sums_due.push_back(s);
                acc_re  = '0;
                acc_im  = '0;
                col_pos = 0;
                row_pos = s.last ? 0 : row_pos + 1;
            end
        end
    endtask

    task automatic check_result();
        t_row_sum                want;
        logic [ROW_W-1:0]        got_row;
        logic signed [ACC_W-1:0] got_re;
        logic signed [ACC_W-1:0] got_im;
        got_row = m_axis_tdata[ROW_W-1:0];
        got_re  = m_axis_tdata[ROW_W +: ACC_W];
        got_im  = m_axis_tdata[ROW_W + ACC_W +: ACC_W];
        if (sums_due.size() == 0) begin
            report($sformatf("row sum for row %0d with none outstanding", got_row));
            return;
        end
        want = sums_due.pop_front();
        if (got_row != want.row)
            report($sformatf("row_index got %0d want %0d", got_row, want.row));
        if (got_re != want.re)
            report($sformatf("row %0d sum_re got %0d want %0d", want.row, got_re, want.re));
        if (got_im != want.im)
            report($sformatf("row %0d sum_im got %0d want %0d", want.row, got_im, want.im));
        if (m_axis_tlast != want.last)
            report($sformatf("row %0d last_row got %0b want %0b", want.row, m_axis_tlast,
                             want.last));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rows_reg = CFG_W'(MAX_DIM_DEF);
            cols_reg = CFG_W'(MAX_DIM_DEF);
            clear_positions();
            sums_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                write_reg(i_cfg_index, i_cfg_data);
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (s_axis_tvalid && s_axis_tready)
                accumulate(t_op'(s_axis_tuser[0]), s_axis_tdata[15:0], s_axis_tdata[31:16]);
        end
        o_errors  <= errors;
        o_pending <= sums_due.size();
    end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
module tb;
    import cmvm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'hFF;
    localparam int STALL_CYCLES  = 200;
    localparam int SETTLE_CYCLES = 16;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [31:0]            s_axis_tdata;  // elem_re, elem_im
    logic [0:0]             s_axis_tuser;  // operation
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;  // row_index, sum_re, sum_im
    logic                   m_axis_tlast;  // last_row
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_W-1:0]       i_cfg_data;

    int fails;
    int pending;
    int src_idle = 0;
    int dst_idle = 0;
    bit stall_req = 1'b0;
    int cur_rows = MAX_DIM_DEF;
    int cur_cols = MAX_DIM_DEF;
    int ld_pos = 0;
    int loaded = 0;
    int sent = 0;

    complex_matrix_vector_multiply_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    cmvm_row_checker u_row_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_errors      (fails),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb: done, errors");
        $finish;
    end

    // receiver side, with one long hold-off on request
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_req) begin
                stall_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= dst_idle);
            end
        end
    end

    function automatic int dim_of(input logic [CFG_W-1:0] r);
        if (r == 0) return 1;
        if (r > MAX_DIM_DEF) return MAX_DIM_DEF;
        return int'(r);
    endfunction

    function automatic logic [15:0] any_part();
        unique case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(input t_op op, input logic [15:0] re, input logic [15:0] im);
        while ($urandom_range(99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {im, re};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
        // track which vector entries hold data so no unwritten entry is ever read
        if (op == OP_LOAD) begin
            if (ld_pos + 1 > loaded) loaded = ld_pos + 1;
            ld_pos = (ld_pos + 1 >= cur_cols) ? 0 : ld_pos + 1;
        end else begin
            ld_pos = 0;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == REG_NUM_ROWS) begin
            cur_rows = dim_of(data);
            ld_pos   = 0;
        end else if (idx == REG_NUM_COLS) begin
            cur_cols = dim_of(data);
            ld_pos   = 0;
        end
    endtask

    task automatic set_dims(input int rows, input int cols);
        write_reg(REG_NUM_ROWS, CFG_W'(rows));
        write_reg(REG_NUM_COLS, CFG_W'(cols));
    endtask

    task automatic load_vector(input int n);
        repeat (n) send_item(OP_LOAD, any_part(), any_part());
    endtask

    task automatic send_matrix(input int n);
        repeat (n) send_item(OP_MATRIX, any_part(), any_part());
    endtask

    task automatic random_traffic(input int n_items);
        int stop_at;
        int pick;
        stop_at = sent + n_items;
        while (sent < stop_at) begin
            pick = $urandom_range(99);
            if (loaded < cur_cols) begin
                load_vector(cur_cols);
            end else if (pick < 10) begin
                load_vector($urandom_range(1, cur_cols));
            end else if (pick < 25) begin
                send_matrix($urandom_range(1, cur_cols));
            end else if (pick < 45) begin
                load_vector(cur_cols);
                send_matrix(cur_cols * $urandom_range(1, cur_rows));
            end else begin
                send_matrix(cur_cols * $urandom_range(1, 2 * cur_rows));
            end
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_idle = 30;
        dst_idle = 66;
        // loads at the reset sizes give no result
        load_vector(3);

        set_dims(2, 3);
        send_item(OP_LOAD, 16'h8000, 16'h8000);
        send_item(OP_LOAD, 16'h7FFF, 16'h7FFF);
        send_item(OP_LOAD, 16'h0000, 16'hFFFF);
        send_item(OP_MATRIX, 16'h8000, 16'h8000);
        send_item(OP_MATRIX, 16'h8000, 16'h7FFF);
        send_item(OP_MATRIX, 16'hFFFF, 16'h0001);
        send_item(OP_MATRIX, 16'h7FFF, 16'h8000);
        send_item(OP_MATRIX, 16'h7FFF, 16'h7FFF);
        send_item(OP_MATRIX, 16'h0000, 16'h0000);
        // row cut short by a vector load, then a partly reloaded vector
        send_item(OP_MATRIX, 16'h8000, 16'h0000);
        send_item(OP_MATRIX, 16'h0000, 16'h8000);
        send_item(OP_LOAD, 16'h8000, 16'h7FFF);
        send_matrix(6);
        write_reg(REG_UNUSED, 9'h1AB);

        set_dims(1, 1);
        random_traffic(30);
        set_dims(4, 3);
        random_traffic(30);
        set_dims(3, 8);
        random_traffic(30);

        // size registers at zero and beyond the maximum
        set_dims(0, 2);
        load_vector(cur_cols);
        send_matrix(2 * cur_cols);
        set_dims(300, 0);
        load_vector(1);
        send_matrix(cur_rows + 10);

        src_idle = 66;
        dst_idle = 30;
        set_dims(2, 5);
        random_traffic(30);
        set_dims(7, 2);
        random_traffic(30);
        set_dims(3, 16);
        random_traffic(30);

        src_idle = 0;
        dst_idle = 0;
        set_dims(3, 1);
        load_vector(1);
        stall_req = 1'b1;
        send_matrix(40);
        set_dims(5, 4);
        random_traffic(30);
        set_dims(1, 7);
        random_traffic(30);
        set_dims(6, 1);
        random_traffic(30);

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fails == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
